>>> sv/ars_pkg.sv
// Shared types and constants for the address range set membership block.
// No dependencies; imported by the top level, the controller and the datapath.
`default_nettype none

package ars_pkg;

  // operation codes of an input item
  typedef logic [1:0] op_t;
  localparam op_t OP_QUERY    = 2'd0;
  localparam op_t OP_WR_SINGLE = 2'd1;
  localparam op_t OP_WR_RANGE = 2'd2;

  // configuration register indexes
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_V4_SINGLE = 2'd0;
  localparam reg_idx_t REG_V4_RANGE  = 2'd1;
  localparam reg_idx_t REG_V6_SINGLE = 2'd2;
  localparam reg_idx_t REG_V6_RANGE  = 2'd3;

  localparam int CNT_W = 9;
  typedef logic [CNT_W-1:0] cnt_t;

  // signed search bound: holds -1 up to the largest clamped count
  typedef logic signed [9:0] sidx_t;

  typedef logic [127:0] addr128_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic probe_cmp;
    logic fin_rd;
    logic fin_cmp;
  } ars_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic probe_hit;
    logic all_done;
    logic need_fin;
  } ars_sts_t;

endpackage

`default_nettype wire

>>> sv/address_range_set_membership.sv
// Top level of the address range set membership block: APB count registers,
// controller and datapath. Depends on ars_pkg, ars_ctrl, ars_dp and ars_ram.
//
// Usage: an item is taken when start is high and busy is low. Operation
// query looks the key up in the single address list (binary search) and in
// the range list (binary search over range starts, then an end check on the
// greatest start below the key). Operations write single and write range
// load one table entry per family at entry_index. Every item gives exactly
// one result: out_valid is high for one cycle with out_hit.
// Timing: a write or unused code shows its result beat in the cycle right
// after accept. A query alternates a table read state and a compare state
// per probe; both searches probe in parallel, one table read each. When the
// range end check runs, a final read state and a final compare state follow
// the probes, then the result beat. busy stays high until the result beat
// is over, so no new item is taken before the last one is through.
// The four counts sit behind the APB port (pready always high). They are to
// be written only while busy is low; the block itself does not enforce this.
// The receiver cannot stall results. Reset clears the counts and the
// controller; table contents are undefined until written, no clearing pass runs.
`default_nettype none

module address_range_set_membership #(
  parameter int LIST_DEPTH = 256
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input item
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   in_operation,
  input  wire logic         in_is_v6,
  input  wire logic [7:0]   in_entry_index,
  input  wire logic [63:0]  in_key_high,
  input  wire logic [63:0]  in_key_low,
  input  wire logic [63:0]  in_range_end_high,
  input  wire logic [63:0]  in_range_end_low,
  // result
  output logic              out_valid,
  output logic              out_hit,
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  import ars_pkg::*;

  cnt_t     v4_single_cnt_r, v4_range_cnt_r, v6_single_cnt_r, v6_range_cnt_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;
  ars_cmd_t cmd;
  ars_sts_t sts;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  // count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_single_cnt_r <= '0;
      v4_range_cnt_r  <= '0;
      v6_single_cnt_r <= '0;
      v6_range_cnt_r  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_V4_SINGLE: v4_single_cnt_r <= pwdata[CNT_W-1:0];
        REG_V4_RANGE:  v4_range_cnt_r  <= pwdata[CNT_W-1:0];
        REG_V6_SINGLE: v6_single_cnt_r <= pwdata[CNT_W-1:0];
        REG_V6_RANGE:  v6_range_cnt_r  <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      REG_V4_SINGLE: prdata = {23'b0, v4_single_cnt_r};
      REG_V4_RANGE:  prdata = {23'b0, v4_range_cnt_r};
      REG_V6_SINGLE: prdata = {23'b0, v6_single_cnt_r};
      REG_V6_RANGE:  prdata = {23'b0, v6_range_cnt_r};
      default:       prdata = '0;
    endcase
  end

  ars_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  ars_dp #(.LIST_DEPTH(LIST_DEPTH)) u_dp (
    .clk               (clk),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_is_v6          (in_is_v6),
    .in_entry_index    (in_entry_index),
    .in_key_high       (in_key_high),
    .in_key_low        (in_key_low),
    .in_range_end_high (in_range_end_high),
    .in_range_end_low  (in_range_end_low),
    .v4_single_count   (v4_single_cnt_r),
    .v4_range_count    (v4_range_cnt_r),
    .v6_single_count   (v6_single_cnt_r),
    .v6_range_count    (v6_range_cnt_r),
    .hit               (out_hit)
  );

  // result beat lasts one cycle and the block returns to idle
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result beat longer than one cycle");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // a result beat only comes while busy
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while idle");

  // non-query items answer on the next cycle with no hit
  a_write_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation != OP_QUERY)) |=> (out_valid && !out_hit))
    else $error("non-query item gave a wrong result");

endmodule

`default_nettype wire

>>> sv/ars_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module ars_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/ars_ctrl.sv
// Sequencing state machine for the address range set membership block.
// Depends on ars_pkg for the command and status structs and operation codes.
`default_nettype none

module ars_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire ars_pkg::op_t      in_operation,
  input  wire ars_pkg::ars_sts_t sts,
  output ars_pkg::ars_cmd_t      cmd,
  output logic                   busy,
  output logic                   out_valid
);

  import ars_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_READ    = 3'd1;
  localparam logic [2:0] S_CMP     = 3'd2;
  localparam logic [2:0] S_FIN_RD  = 3'd3;
  localparam logic [2:0] S_FIN_CMP = 3'd4;
  localparam logic [2:0] S_RESP    = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_operation == OP_QUERY) ? S_READ : S_RESP;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.probe_cmp = 1'b1;
        priority if (sts.probe_hit) begin
          state_nxt = S_RESP;
        end else if (sts.all_done) begin
          state_nxt = sts.need_fin ? S_FIN_RD : S_RESP;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_FIN_RD: begin
        cmd.fin_rd = 1'b1;
        state_nxt  = S_FIN_CMP;
      end
      S_FIN_CMP: begin
        cmd.fin_cmp = 1'b1;
        state_nxt   = S_RESP;
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

endmodule

`default_nettype wire

>>> sv/ars_dp.sv
// Datapath: entry tables, key register and the two binary search engines.
// Depends on ars_pkg and instantiates ars_ram for the three tables.
`default_nettype none

module ars_dp #(
  parameter int LIST_DEPTH = 256
) (
  input  wire logic              clk,
  input  wire ars_pkg::ars_cmd_t cmd,
  output ars_pkg::ars_sts_t      sts,
  input  wire ars_pkg::op_t      in_operation,
  input  wire logic              in_is_v6,
  input  wire logic [7:0]        in_entry_index,
  input  wire logic [63:0]       in_key_high,
  input  wire logic [63:0]       in_key_low,
  input  wire logic [63:0]       in_range_end_high,
  input  wire logic [63:0]       in_range_end_low,
  input  wire ars_pkg::cnt_t     v4_single_count,
  input  wire ars_pkg::cnt_t     v4_range_count,
  input  wire ars_pkg::cnt_t     v6_single_count,
  input  wire ars_pkg::cnt_t     v6_range_count,
  output logic                   hit
);

  import ars_pkg::*;

  // both families share a table; the family bit is the low address bit
  localparam int RAM_DEPTH = 2 * LIST_DEPTH;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam logic [16:0] DEPTH_W = 17'(LIST_DEPTH);

  function automatic logic [9:0] clamp_cnt(input cnt_t c);
    logic [16:0] ce;
    begin
      ce = {8'b0, c};
      clamp_cnt = (ce > DEPTH_W) ? DEPTH_W[9:0] : ce[9:0];
    end
  endfunction

  addr128_t key_r;
  logic     v6_r;
  sidx_t    s_low_r, s_high_r, r_low_r, r_high_r;
  logic     s_done_r, r_done_r;
  logic     hit_r;

  sidx_t    s_low_nxt, s_high_nxt, r_low_nxt, r_high_nxt;
  logic     s_done_nxt, r_done_nxt;
  logic     s_found, r_found;
  sidx_t    s_mid, r_mid;
  logic [10:0] s_sum, r_sum;

  addr128_t key_in, end_in;
  logic     idx_ok;
  logic [9:0] s_cnt, r_cnt;

  logic [RAM_AW-1:0] waddr;
  logic [RAM_AW-1:0] s_raddr, st_raddr, end_raddr;
  logic [8:0]        r_idx;
  addr128_t          s_rd, st_rd, end_rd;
  logic              s_we, rng_we;

  // masked input key and range end; IPv4 keeps bits 31:0 only
  assign key_in = in_is_v6 ? {in_key_high, in_key_low} : {96'b0, in_key_low[31:0]};
  assign end_in = in_is_v6 ? {in_range_end_high, in_range_end_low}
                           : {96'b0, in_range_end_low[31:0]};

  // table writes happen on the accept beat
  assign idx_ok = ({9'b0, in_entry_index} < DEPTH_W);
  assign s_we   = cmd.load && (in_operation == OP_WR_SINGLE) && idx_ok;
  assign rng_we = cmd.load && (in_operation == OP_WR_RANGE) && idx_ok;
  assign waddr  = RAM_AW'({1'b0, in_entry_index, in_is_v6});

  // clamped counts for the selected family
  assign s_cnt = clamp_cnt(in_is_v6 ? v6_single_count : v4_single_count);
  assign r_cnt = clamp_cnt(in_is_v6 ? v6_range_count : v4_range_count);

  // probe midpoints
  assign s_sum = 11'(s_low_r) + 11'(s_high_r);
  assign r_sum = 11'(r_low_r) + 11'(r_high_r);
  assign s_mid = sidx_t'(s_sum[10:1]);
  assign r_mid = sidx_t'(r_sum[10:1]);

  // read addresses; the final check reads start and end at the upper bound
  assign r_idx     = cmd.fin_rd ? r_high_r[8:0] : r_mid[8:0];
  assign s_raddr   = RAM_AW'({s_mid[8:0], v6_r});
  assign st_raddr  = RAM_AW'({r_idx, v6_r});
  assign end_raddr = RAM_AW'({r_high_r[8:0], v6_r});

  ars_ram #(.WIDTH(128), .DEPTH(RAM_DEPTH)) u_single_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (waddr),
    .wdata (key_in),
    .raddr (s_raddr),
    .rdata (s_rd)
  );

  ars_ram #(.WIDTH(128), .DEPTH(RAM_DEPTH)) u_start_ram (
    .clk   (clk),
    .we    (rng_we),
    .waddr (waddr),
    .wdata (key_in),
    .raddr (st_raddr),
    .rdata (st_rd)
  );

  ars_ram #(.WIDTH(128), .DEPTH(RAM_DEPTH)) u_end_ram (
    .clk   (clk),
    .we    (rng_we),
    .waddr (waddr),
    .wdata (end_in),
    .raddr (end_raddr),
    .rdata (end_rd)
  );

  // single list search step
  always_comb begin
    s_low_nxt  = s_low_r;
    s_high_nxt = s_high_r;
    s_done_nxt = s_done_r;
    s_found    = 1'b0;
    if (cmd.probe_cmp && !s_done_r) begin
      if (key_r == s_rd) begin
        s_found    = 1'b1;
        s_done_nxt = 1'b1;
      end else if (key_r < s_rd) begin
        s_high_nxt = s_mid - sidx_t'(1);
      end else begin
        s_low_nxt = s_mid + sidx_t'(1);
      end
      if (!s_found && (s_low_nxt > s_high_nxt)) begin
        s_done_nxt = 1'b1;
      end
    end
  end

  // range start search step
  always_comb begin
    r_low_nxt  = r_low_r;
    r_high_nxt = r_high_r;
    r_done_nxt = r_done_r;
    r_found    = 1'b0;
    if (cmd.probe_cmp && !r_done_r) begin
      if (key_r == st_rd) begin
        r_found    = 1'b1;
        r_done_nxt = 1'b1;
      end else if (key_r < st_rd) begin
        r_high_nxt = r_mid - sidx_t'(1);
      end else begin
        r_low_nxt = r_mid + sidx_t'(1);
      end
      if (!r_found && (r_low_nxt > r_high_nxt)) begin
        r_done_nxt = 1'b1;
      end
    end
  end

  assign sts.probe_hit = s_found | r_found;
  assign sts.all_done  = s_done_nxt & r_done_nxt;
  assign sts.need_fin  = !r_high_nxt[9];

  // search registers and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= key_in;
      v6_r     <= in_is_v6;
      s_low_r  <= '0;
      s_high_r <= $signed(s_cnt) - sidx_t'(1);
      s_done_r <= (s_cnt == 10'd0);
      r_low_r  <= '0;
      r_high_r <= $signed(r_cnt) - sidx_t'(1);
      r_done_r <= (r_cnt == 10'd0);
      hit_r    <= 1'b0;
    end else begin
      s_low_r  <= s_low_nxt;
      s_high_r <= s_high_nxt;
      s_done_r <= s_done_nxt;
      r_low_r  <= r_low_nxt;
      r_high_r <= r_high_nxt;
      r_done_r <= r_done_nxt;
      if (cmd.probe_cmp && (s_found || r_found)) begin
        hit_r <= 1'b1;
      end else if (cmd.fin_cmp) begin
        hit_r <= !(key_r < st_rd) && !(end_rd < key_r);
      end
    end
  end

  assign hit = hit_r;

endmodule

`default_nettype wire

>>> sim/ars_hit_checker.sv
// Checker for the address range set membership block: watches the item, result and
// count-register channels, predicts every hit beat and compares. Depends on ars_pkg.
module ars_hit_checker #(
  parameter int LIST_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [1:0]  in_operation,
  input  wire logic        in_is_v6,
  input  wire logic [7:0]  in_entry_index,
  input  wire logic [63:0] in_key_high,
  input  wire logic [63:0] in_key_low,
  input  wire logic [63:0] in_range_end_high,
  input  wire logic [63:0] in_range_end_low,
  input  wire logic        out_valid,
  input  wire logic        out_hit,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               mismatch_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import ars_pkg::*;

  // own copy of the tables, family 0 is IPv4 (zero extended), 1 is IPv6
  addr128_t singles [2][LIST_DEPTH];
  addr128_t starts  [2][LIST_DEPTH];
  addr128_t ends    [2][LIST_DEPTH];
  cnt_t     counts  [4];
  logic     pending_hits [$];
  int       mismatches = 0;

  // binary search of one list; a range list also gets the end check on the
  // greatest start below the key
  function automatic logic list_hit(logic fam, logic ranges, cnt_t count, addr128_t key);
    int       lo;
    int       hi;
    int       mid;
    int       n;
    addr128_t e;
    n = (int'(count) > LIST_DEPTH) ? LIST_DEPTH : int'(count);
    if (n == 0) return 1'b0;
    lo = 0;
    hi = n - 1;
    do begin
      mid = (lo + hi) / 2;
      e = ranges ? starts[fam][mid] : singles[fam][mid];
      if (key < e) hi = mid - 1;
      else if (key > e) lo = mid + 1;
      else return 1'b1;
    end while (lo <= hi);
    if (!ranges || hi < 0) return 1'b0;
    if (key < starts[fam][hi]) return 1'b0;
    return key <= ends[fam][hi];
  endfunction

  task automatic note_mismatch(string what, logic want, logic got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: %s: predicted hit %0b, block gave %0b", $time, what, want, got);
  endtask

  always @(posedge clk) begin
    logic     fam;
    logic     want;
    addr128_t key;
    addr128_t stop;
    if (!rst_n) begin
      foreach (counts[i]) counts[i] = '0;
      pending_hits.delete();
    end else begin
      // result beat against the oldest prediction
      if (out_valid) begin
        if (pending_hits.size() == 0) note_mismatch("result beat with nothing pending",
                                                    1'b0, out_hit);
        else begin
          want = pending_hits.pop_front();
          if (out_hit !== want) note_mismatch("hit mismatch", want, out_hit);
        end
      end
      // count register write
      if (psel && penable && pwrite && pready)
        counts[reg_idx_t'(paddr[3:2])] = pwdata[CNT_W-1:0];
      // accepted item beat
      if (start && !busy) begin
        fam  = in_is_v6;
        key  = fam ? {in_key_high, in_key_low} : {96'd0, in_key_low[31:0]};
        stop = fam ? {in_range_end_high, in_range_end_low} : {96'd0, in_range_end_low[31:0]};
        want = 1'b0;
        case (in_operation)
          OP_QUERY: begin
            want = list_hit(fam, 1'b0, counts[fam ? REG_V6_SINGLE : REG_V4_SINGLE], key) ||
                   list_hit(fam, 1'b1, counts[fam ? REG_V6_RANGE : REG_V4_RANGE], key);
          end
          OP_WR_SINGLE: begin
            if (in_entry_index < LIST_DEPTH) singles[fam][in_entry_index] = key;
          end
          OP_WR_RANGE: begin
            if (in_entry_index < LIST_DEPTH) begin
              starts[fam][in_entry_index] = key;
              ends[fam][in_entry_index]   = stop;
            end
          end
          default: ;
        endcase
        pending_hits.push_back(want);
      end
    end
    mismatch_count <= mismatches;
    pending_count  <= pending_hits.size();
  end

endmodule

>>> sim/tb_address_range_set_membership.sv
// Testbench top for the address range set membership block: drives items and the
// count registers, gives the verdict. Depends on ars_pkg, the block and ars_hit_checker.
module tb_address_range_set_membership;
  timeunit 1ns;
  timeprecision 1ps;
  import ars_pkg::*;

  // the one operation code the block does not use
  localparam op_t OP_SPARE = 2'd3;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  op_t         in_operation = OP_QUERY;
  logic        in_is_v6 = 1'b0;
  logic [7:0]  in_entry_index = '0;
  logic [63:0] in_key_high = '0;
  logic [63:0] in_key_low = '0;
  logic [63:0] in_range_end_high = '0;
  logic [63:0] in_range_end_low = '0;
  logic        out_valid;
  logic        out_hit;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          mismatch_count;
  int          pending_count;

  // what has been loaded into each list, indexed like the count registers
  addr128_t tab_key [4][256];
  addr128_t tab_end [4][256];
  bit       tab_set [4][256];
  int       live_n  [4];
  int       burst_left = 0;

  address_range_set_membership #(.LIST_DEPTH(256)) uut (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_is_v6, .in_entry_index, .in_key_high, .in_key_low,
    .in_range_end_high, .in_range_end_low,
    .out_valid, .out_hit,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  ars_hit_checker #(.LIST_DEPTH(256)) hit_chk (
    .clk, .rst_n, .start, .busy,
    .in_operation, .in_is_v6, .in_entry_index, .in_key_high, .in_key_low,
    .in_range_end_high, .in_range_end_low,
    .out_valid, .out_hit,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .mismatch_count, .pending_count
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic addr128_t rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // IPv4 values travel with random bits above bit 31
  function automatic addr128_t with_junk(logic v6, addr128_t a);
    addr128_t r;
    r = rand128();
    if (v6) return a;
    r[31:0] = a[31:0];
    return r;
  endfunction

  function automatic int written_prefix(reg_idx_t l);
    int p;
    p = 0;
    while (p < 256 && tab_set[l][p]) p++;
    return p;
  endfunction

  // one item beat, sender idles in bursts
  task automatic issue(op_t op, logic v6, logic [7:0] idx,
                       logic [63:0] kh, logic [63:0] kl, logic [63:0] eh, logic [63:0] el);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 26);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_operation      <= op;
    in_is_v6          <= v6;
    in_entry_index    <= idx;
    in_key_high       <= kh;
    in_key_low        <= kl;
    in_range_end_high <= eh;
    in_range_end_low  <= el;
    start             <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // wait until every hit beat is back and the block is idle
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_count != 0 || busy);
    burst_left = 0;
  endtask

  task automatic put_entry(reg_idx_t l, logic [7:0] idx, addr128_t k, addr128_t e);
    addr128_t kb;
    addr128_t eb;
    if (!l[1]) begin
      k[127:32] = '0;
      e[127:32] = '0;
    end
    tab_key[l][idx] = k;
    tab_end[l][idx] = e;
    tab_set[l][idx] = 1'b1;
    kb = with_junk(l[1], k);
    eb = l[0] ? with_junk(l[1], e) : rand128();
    issue(l[0] ? OP_WR_RANGE : OP_WR_SINGLE, l[1], idx,
          kb[127:64], kb[63:0], eb[127:64], eb[63:0]);
  endtask

  task automatic query(logic v6, addr128_t k);
    addr128_t kb;
    addr128_t eb;
    kb = with_junk(v6, k);
    eb = rand128();
    issue(OP_QUERY, v6, 8'($urandom), kb[127:64], kb[63:0], eb[127:64], eb[63:0]);
  endtask

  // sorted list with random spacing; ranges never overlap, a few are inverted
  task automatic fill_list(reg_idx_t l, int n);
    addr128_t cur;
    addr128_t gap;
    addr128_t e;
    cur = l[1] ? (rand128() >> $urandom_range(1, 40)) : addr128_t'($urandom_range(0, 1 << 20));
    for (int i = 0; i < n; i++) begin
      gap = l[1] ? (rand128() >> $urandom_range(20, 110)) + 1
                 : addr128_t'($urandom_range(1, 1 << 23));
      e = cur + rand128() % gap;
      if (l[0] && cur != 0 && $urandom_range(0, 19) == 0) e = cur - 1;
      put_entry(l, 8'(i), cur, e);
      cur = cur + gap;
    end
  endtask

  // keys near loaded entries, the rest random
  function automatic addr128_t pick_key(logic v6);
    reg_idx_t ls;
    reg_idx_t lr;
    int       i;
    addr128_t k;
    addr128_t d;
    ls = v6 ? REG_V6_SINGLE : REG_V4_SINGLE;
    lr = v6 ? REG_V6_RANGE : REG_V4_RANGE;
    k = rand128();
    if (!v6 && $urandom_range(0, 1)) k = addr128_t'($urandom_range(0, 1 << 31));
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        if (live_n[ls] > 0) begin
          i = $urandom_range(0, live_n[ls] - 1);
          k = tab_key[ls][i];
          if ($urandom_range(0, 2) == 0) k = $urandom_range(0, 1) ? k + 1 : k - 1;
        end
      end
      3, 4, 5, 6: begin
        if (live_n[lr] > 0) begin
          i = $urandom_range(0, live_n[lr] - 1);
          k = tab_key[lr][i];
          d = tab_end[lr][i] - k;
          case ($urandom_range(0, 4))
            0: ;
            1: k = tab_end[lr][i];
            2: k = tab_end[lr][i] + 1;
            3: k = k - 1;
            default: if (tab_end[lr][i] >= k && d != 0) k = k + rand128() % d;
          endcase
        end
      end
      default: ;
    endcase
    return k;
  endfunction

  // count for a list, never past what has been loaded from index 0
  function automatic cnt_t pick_count(reg_idx_t l, int n);
    int p;
    p = written_prefix(l);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return (p == 256) ? cnt_t'($urandom_range(256, 511)) : cnt_t'(p);
      2: return cnt_t'($urandom_range(0, p));
      default: return cnt_t'(n);
    endcase
  endfunction

  // write all four count registers, back to back transfers
  task automatic load_counts(cnt_t c [4]);
    logic [31:0] w;
    for (int r = 0; r < 4; r++) begin
      w = $urandom;
      w[CNT_W-1:0] = c[r];
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx_t'(r), 2'b00};
      pwdata  <= w;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      live_n[r] = (c[r] > 256) ? 256 : int'(c[r]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    cnt_t c [4];
    int   n [4];
    int   queries;
    logic v6_sel;
    foreach (live_n[i]) live_n[i] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty lists never match, spare code gives no hit
    query(1'b0, '0);
    query(1'b1, {128{1'b1}});
    issue(OP_SPARE, 1'b1, 8'hFF, '1, '1, '1, '1);

    // small hand-made lists with extreme values
    put_entry(REG_V4_SINGLE, 8'd0, 128'h0, rand128());
    put_entry(REG_V4_SINGLE, 8'd1, 128'h1000, rand128());
    put_entry(REG_V4_SINGLE, 8'd2, 128'hFFFF_FFFF, rand128());
    put_entry(REG_V4_SINGLE, 8'd255, 128'h1234, rand128());
    put_entry(REG_V4_RANGE, 8'd0, 128'h10, 128'h20);
    put_entry(REG_V4_RANGE, 8'd1, 128'h8000_0000, 128'hFFFF_FFFF);
    put_entry(REG_V6_SINGLE, 8'd0, 128'h0, rand128());
    put_entry(REG_V6_SINGLE, 8'd1, {128{1'b1}}, rand128());
    put_entry(REG_V6_RANGE, 8'd0, 128'h1_0000_0000_0000_0000, 128'h1_FFFF_FFFF_FFFF_FFFF);
    put_entry(REG_V6_RANGE, 8'd1, {64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, {128{1'b1}});
    drain();
    c = '{cnt_t'(3), cnt_t'(2), cnt_t'(2), cnt_t'(2)};
    load_counts(c);

    // exact single, range start, range end, just outside, below the first start
    query(1'b0, 128'h0);
    query(1'b0, 128'hFFFF_FFFF);
    query(1'b0, 128'h10);
    query(1'b0, 128'h20);
    query(1'b0, 128'h21);
    query(1'b0, 128'h0F);
    query(1'b0, 128'h1000);
    query(1'b1, 128'h1_5555_5555_5555_5555);
    query(1'b1, 128'h2_0000_0000_0000_0000);
    query(1'b1, {128{1'b1}});
    query(1'b1, 128'h1);

    // random phases; two of them fill one family's lists, one of these with clamped counts
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      for (int l = 0; l < 4; l++) begin
        if ((ph == 1 && l < 2) || (ph == 3 && l >= 2)) n[l] = 256;
        else n[l] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 16);
        fill_list(reg_idx_t'(l), n[l]);
      end
      drain();
      for (int l = 0; l < 4; l++)
        c[l] = (n[l] == 256) ? ((ph == 1) ? cnt_t'(256) : cnt_t'(511))
                             : pick_count(reg_idx_t'(l), n[l]);
      load_counts(c);
      queries = (ph == 1 || ph == 3) ? 100 : 70;
      for (int q = 0; q < queries; q++) begin
        case ($urandom_range(0, 15))
          0: issue(OP_SPARE, 1'($urandom), 8'($urandom), {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
          1: put_entry(reg_idx_t'($urandom_range(0, 3)), 8'($urandom), rand128(), rand128());
          default: begin
            v6_sel = 1'($urandom);
            query(v6_sel, pick_key(v6_sel));
          end
        endcase
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
